[rtl/wib_pkg.sv]
// shared constants, types and tables of the waypoint initial bearing block
package wib_pkg;

  localparam int FRAC_BITS  = 20;
  localparam int ITERATIONS = 24;
  localparam int TURN_SHIFT = 32 - FRAC_BITS;
  // degrees * 2^TURN_SHIFT / 360 == degrees * 2^SCALE / 45
  localparam int SCALE      = TURN_SHIFT - 3;
  // ceil(2^34 / 45), exact floor division by 45 for operands below 2^29
  localparam logic [28:0] RECIP45 = 29'd381774871;
  localparam int RECIP_SHIFT = 34;

  localparam int DW = 34;
  localparam logic signed [DW-1:0] GAIN_Q30 = 34'sd652032874;
  localparam int Q30_BIT = 30;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [5:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic        vector_mode;
    logic [4:0]  shift;
    logic [31:0] arc;
  } step_t;

  function automatic logic [31:0] arc_at(input int i);
    logic [31:0] a;
    case (i)
      0: a = 32'd536870912;  1: a = 32'd316933406;  2: a = 32'd167458907;
      3: a = 32'd85004756;   4: a = 32'd42667331;   5: a = 32'd21354465;
      6: a = 32'd10679838;   7: a = 32'd5340245;    8: a = 32'd2670163;
      9: a = 32'd1335087;    10: a = 32'd667544;    11: a = 32'd333772;
      12: a = 32'd166886;    13: a = 32'd83443;     14: a = 32'd41722;
      15: a = 32'd20861;     16: a = 32'd10430;     17: a = 32'd5215;
      18: a = 32'd2608;      19: a = 32'd1304;      20: a = 32'd652;
      21: a = 32'd326;       22: a = 32'd163;       23: a = 32'd81;
      24: a = 32'd41;        25: a = 32'd20;        26: a = 32'd10;
      27: a = 32'd5;         28: a = 32'd3;         29: a = 32'd1;
      30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

[rtl/waypoint_initial_bearing_top.sv]
// top level of the waypoint initial bearing block
//
// computes the initial great-circle bearing from a start waypoint to a
// destination waypoint, floored to whole degrees 0..359, plus its three
// ascii digits
// input channel: in_valid / in_ready, one waypoint pair per transaction,
//   latitudes and longitudes in signed fixed-point degrees
// output channel: out_valid / out_ready, one bearing per transaction
// structure: angle conversion (4 stages), a row of rotation cordic cells
//   (three sine/cosine units side by side, ITERATIONS cells), three product
//   stages, five normalize stages, a row of vectoring cordic cells
//   (ITERATIONS cells), then bearing and digit stages
// throughput: one transaction per cycle while not stalled, set by the fully pipelined cell rows
// stall: when out_ready is low with a result waiting, the whole pipeline
//   freezes and in_ready drops; nothing is lost or repeated
// reset: rst clears all stage valid bits, the block is empty afterward
module waypoint_initial_bearing_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [27:0] start_latitude,
  input  logic signed [28:0] start_longitude,
  input  logic signed [27:0] end_latitude,
  input  logic signed [28:0] end_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [8:0]         bearing_degrees,
  output logic [5:0]         hundreds_ascii,
  output logic [5:0]         tens_ascii,
  output logic [5:0]         units_ascii
);

  localparam int N  = wib_pkg::ITERATIONS;
  localparam int DW = wib_pkg::DW;

  // global advance: whole pipeline moves unless a result is held
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- angle conversion ----------------
  logic [31:0] lat1_t, lon1_t, lat2_t, lon2_t;
  logic [3:0]  tv;
  logic [3:0]  teq;

  wib_turns u_lat1 (.clk, .en, .degrees({start_latitude[27], start_latitude}),
                    .turns(lat1_t));
  wib_turns u_lon1 (.clk, .en, .degrees(start_longitude), .turns(lon1_t));
  wib_turns u_lat2 (.clk, .en, .degrees({end_latitude[27], end_latitude}),
                    .turns(lat2_t));
  wib_turns u_lon2 (.clk, .en, .degrees(end_longitude), .turns(lon2_t));

  always_ff @(posedge clk) begin
    if (rst) begin
      tv <= '0;
    end else if (en) begin
      tv <= {tv[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      teq <= {teq[2:0], start_latitude == end_latitude};
    end
  end

  logic [31:0] dlon;
  logic        same0;
  assign dlon  = lon2_t - lon1_t;
  assign same0 = teq[3] && (dlon == 32'd0);

  // ---------------- sine/cosine cell rows ----------------
  // unit 0: start latitude, unit 1: end latitude, unit 2: longitude difference
  logic [31:0]          ang [3];
  logic signed [DW-1:0] rx [N+1][3];
  logic signed [DW-1:0] ry [N+1][3];
  logic signed [DW-1:0] rz [N+1][3];
  logic [1:0]           rq [N+1][3];
  logic                 rv [N+1];
  logic                 rs [N+1];

  assign ang[0] = lat1_t;
  assign ang[1] = lat2_t;
  assign ang[2] = dlon;
  assign rv[0]  = tv[3];
  assign rs[0]  = same0;

  for (genvar k = 0; k < 3; k++) begin : g_seed
    assign rx[0][k] = wib_pkg::GAIN_Q30;
    assign ry[0][k] = '0;
    assign rz[0][k] = DW'(ang[k][29:0]);
    assign rq[0][k] = ang[k][31:30];
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    wib_pkg::step_t st;
    assign st.vector_mode = 1'b0;
    assign st.shift       = 5'(i);
    assign st.arc         = wib_pkg::arc_at(i);
    for (genvar k = 0; k < 3; k++) begin : g_unit
      wib_cell u_cell (
        .clk, .en, .step(st),
        .x_in(rx[i][k]), .y_in(ry[i][k]), .z_in(rz[i][k]),
        .x(rx[i+1][k]), .y(ry[i+1][k]), .z(rz[i+1][k])
      );
      always_ff @(posedge clk) begin
        if (en) begin
          rq[i+1][k] <= rq[i][k];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i+1] <= 1'b0;
      end else if (en) begin
        rv[i+1] <= rv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rs[i+1] <= rs[i];
      end
    end
  end

  // quadrant fold back to cosine and sine
  logic signed [31:0] cv [3];
  logic signed [31:0] sv [3];
  for (genvar k = 0; k < 3; k++) begin : g_fold
    always_comb begin
      case (rq[N][k])
        2'd1: begin
          cv[k] = 32'(-ry[N][k]);
          sv[k] = 32'(rx[N][k]);
        end
        2'd2: begin
          cv[k] = 32'(-rx[N][k]);
          sv[k] = 32'(-ry[N][k]);
        end
        2'd3: begin
          cv[k] = 32'(ry[N][k]);
          sv[k] = 32'(-rx[N][k]);
        end
        default: begin
          cv[k] = 32'(rx[N][k]);
          sv[k] = 32'(ry[N][k]);
        end
      endcase
    end
  end

  // ---------------- products ----------------
  logic signed [63:0] yp, ap, bp, bq;
  logic signed [31:0] cd1;
  logic signed [DW-1:0] y2, a2, x3, y3;
  logic p1v, p2v, p3v, p1s, p2s, p3s;
  logic signed [63:0] b_sh;
  logic signed [63:0] bq_sh;

  assign b_sh  = bp >>> wib_pkg::Q30_BIT;
  assign bq_sh = bq >>> wib_pkg::Q30_BIT;

  always_ff @(posedge clk) begin
    if (en) begin
      // y = sin dlon cos lat2, x = cos lat1 sin lat2 - sin lat1 cos lat2 cos dlon
      yp  <= 64'(sv[2]) * 64'(cv[1]);
      ap  <= 64'(cv[0]) * 64'(sv[1]);
      bp  <= 64'(sv[0]) * 64'(cv[1]);
      cd1 <= cv[2];
      p1s <= rs[N];
      y2  <= DW'(yp >>> wib_pkg::Q30_BIT);
      a2  <= DW'(ap >>> wib_pkg::Q30_BIT);
      bq  <= 64'(signed'(b_sh[31:0])) * 64'(cd1);
      p2s <= p1s;
      y3  <= y2;
      x3  <= a2 - DW'(bq_sh);
      p3s <= p2s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
    end else if (en) begin
      p1v <= rv[N];
      p2v <= p1v;
      p3v <= p2v;
    end
  end

  // ---------------- normalize: binary search on the doubling count ----------------
  logic signed [DW-1:0] nx [6];
  logic signed [DW-1:0] ny [6];
  logic                 nv [6];
  logic                 nz [6];

  assign nx[0] = x3;
  assign ny[0] = y3;
  assign nv[0] = p3v;
  assign nz[0] = p3s || (x3 == '0 && y3 == '0);

  for (genvar j = 0; j < 5; j++) begin : g_norm
    localparam int SH = 16 >> j;
    logic [DW-1:0] ax, ay;
    logic          small_vec;
    assign ax = nx[j][DW-1] ? DW'(-nx[j]) : DW'(nx[j]);
    assign ay = ny[j][DW-1] ? DW'(-ny[j]) : DW'(ny[j]);
    assign small_vec = (ax < (DW'(1) << (wib_pkg::Q30_BIT - SH)))
                    && (ay < (DW'(1) << (wib_pkg::Q30_BIT - SH)));
    always_ff @(posedge clk) begin
      if (en) begin
        nx[j+1] <= small_vec ? nx[j] <<< SH : nx[j];
        ny[j+1] <= small_vec ? ny[j] <<< SH : ny[j];
        nz[j+1] <= nz[j];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        nv[j+1] <= 1'b0;
      end else if (en) begin
        nv[j+1] <= nv[j];
      end
    end
  end

  // ---------------- vectoring cell row ----------------
  logic signed [DW-1:0] vx [N+1];
  logic signed [DW-1:0] vy [N+1];
  logic signed [DW-1:0] vz [N+1];
  logic                 vv [N+1];
  logic                 vzero [N+1];

  // left half plane: mirror through the origin and start at half a turn
  assign vx[0]    = nx[5][DW-1] ? -nx[5] : nx[5];
  assign vy[0]    = nx[5][DW-1] ? -ny[5] : ny[5];
  assign vz[0]    = nx[5][DW-1] ? DW'(wib_pkg::HALF_TURN) : '0;
  assign vv[0]    = nv[5];
  assign vzero[0] = nz[5];

  for (genvar i = 0; i < N; i++) begin : g_vec
    wib_pkg::step_t st;
    assign st.vector_mode = 1'b1;
    assign st.shift       = 5'(i);
    assign st.arc         = wib_pkg::arc_at(i);
    wib_cell u_cell (
      .clk, .en, .step(st),
      .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x(vx[i+1]), .y(vy[i+1]), .z(vz[i+1])
    );
    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else if (en) begin
        vv[i+1] <= vv[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        vzero[i+1] <= vzero[i];
      end
    end
  end

  // ---------------- degrees and digits ----------------
  logic [40:0] deg_prod;
  logic [8:0]  bdeg;
  logic        bv;
  logic [8:0]  ddeg;
  logic [1:0]  dh;
  logic [6:0]  drem;
  logic        dv;
  logic [1:0]  hsel;
  logic [8:0]  hsub;
  logic [14:0] tprod;
  logic [3:0]  tdig;
  logic [6:0]  udig;

  // floor(angle * 360 / 2^32)
  assign deg_prod = 41'(vz[N][31:0]) * 41'd360;

  always_comb begin
    if (bdeg >= 9'd300) begin
      hsel = 2'd3;
      hsub = 9'd300;
    end else if (bdeg >= 9'd200) begin
      hsel = 2'd2;
      hsub = 9'd200;
    end else if (bdeg >= 9'd100) begin
      hsel = 2'd1;
      hsub = 9'd100;
    end else begin
      hsel = 2'd0;
      hsub = 9'd0;
    end
  end

  // divide by ten for values below 100: (r * 205) >> 11
  assign tprod = 15'(drem) * 15'd205;
  assign tdig  = tprod[14:11];
  assign udig  = drem - 7'((7'(tdig) << 3) + (7'(tdig) << 1));

  always_ff @(posedge clk) begin
    if (en) begin
      bdeg            <= vzero[N] ? 9'd0 : deg_prod[40:32];
      ddeg            <= bdeg;
      dh              <= hsel;
      drem            <= 7'(bdeg - hsub);
      bearing_degrees <= ddeg;
      hundreds_ascii  <= wib_pkg::ASCII_ZERO + 6'(dh);
      tens_ascii      <= wib_pkg::ASCII_ZERO + 6'(tdig);
      units_ascii     <= wib_pkg::ASCII_ZERO + 6'(udig[3:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bv        <= 1'b0;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      bv        <= vv[N];
      dv        <= bv;
      out_valid <= dv;
    end
  end

  // ---------------- checks ----------------
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bearing_degrees)
      && $stable(units_ascii))
    else $error("held result changed during stall");

  a_digits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (10'(hundreds_ascii - wib_pkg::ASCII_ZERO) * 10'd100
      + 10'(tens_ascii - wib_pkg::ASCII_ZERO) * 10'd10
      + 10'(units_ascii - wib_pkg::ASCII_ZERO)) == 10'(bearing_degrees))
    else $error("ascii digits disagree with bearing");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bearing_degrees < 9'd360)
    else $error("bearing out of range");

endmodule

[rtl/wib_turns.sv]
// four-stage conversion of fixed-point degrees into a 32-bit binary angle
module wib_turns (
  input  logic               clk,
  input  logic               en,
  input  logic signed [28:0] degrees,
  output logic [31:0]        turns
);

  logic [28:0] mag1;
  logic        neg1;
  logic [28:0] mag2;
  logic [22:0] q2;
  logic        neg2;
  logic [22:0] q3;
  logic [5:0]  r3;
  logic        neg3;

  logic [63:0] prod_q;
  logic [28:0] q_ext;
  logic [28:0] rem_full;
  logic [63:0] prod_f;
  logic [63:0] sum;

  assign prod_q   = 64'(mag1) * 64'(wib_pkg::RECIP45);
  assign q_ext    = 29'(q2);
  assign rem_full = mag2 - ((q_ext << 5) + (q_ext << 3) + (q_ext << 2) + q_ext);
  assign prod_f   = (64'(r3) << wib_pkg::SCALE) * 64'(wib_pkg::RECIP45);
  assign sum      = (64'(q3) << wib_pkg::SCALE) + (prod_f >> wib_pkg::RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      mag1  <= degrees[28] ? 29'(-degrees) : 29'(degrees);
      neg1  <= degrees[28];
      q2    <= prod_q[wib_pkg::RECIP_SHIFT +: 23];
      mag2  <= mag1;
      neg2  <= neg1;
      q3    <= q2;
      r3    <= rem_full[5:0];
      neg3  <= neg2;
      turns <= neg3 ? -sum[31:0] : sum[31:0];
    end
  end

endmodule

[rtl/wib_cell.sv]
// one registered cordic micro-rotation, rotation or vectoring
module wib_cell (
  input  logic                          clk,
  input  logic                          en,
  input  wib_pkg::step_t                step,
  input  logic signed [wib_pkg::DW-1:0] x_in,
  input  logic signed [wib_pkg::DW-1:0] y_in,
  input  logic signed [wib_pkg::DW-1:0] z_in,
  output logic signed [wib_pkg::DW-1:0] x,
  output logic signed [wib_pkg::DW-1:0] y,
  output logic signed [wib_pkg::DW-1:0] z
);

  logic                          ccw;
  logic signed [wib_pkg::DW-1:0] xs;
  logic signed [wib_pkg::DW-1:0] ys;
  logic signed [wib_pkg::DW-1:0] arc;

  assign ccw = step.vector_mode ? y_in[wib_pkg::DW-1] : ~z_in[wib_pkg::DW-1];
  assign xs  = x_in >>> step.shift;
  assign ys  = y_in >>> step.shift;
  assign arc = wib_pkg::DW'(step.arc);

  always_ff @(posedge clk) begin
    if (en) begin
      x <= ccw ? x_in - ys : x_in + ys;
      y <= ccw ? y_in + xs : y_in - xs;
      z <= ccw ? z_in - arc : z_in + arc;
    end
  end

endmodule
